// ----- hw/rtl/assert_macros.svh -----
// Assertion macros for the RTL; the top level includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked property, disabled while reset is high.
`define ASSERT_CHECK(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
// Checked property that holds through reset as well.
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");
`else
`define ASSERT_CHECK(lbl, clk, rst, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ----- hw/rtl/ous_pkg.sv -----
// Shared types and constants of the ordered unique set table.
`timescale 1ns / 1ps
package ous_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int CODE_W       = 6;
  localparam int POS_W        = 6;
  localparam int IDX_OUT_W    = 6;
  localparam int CNT_OUT_W    = 7;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_LOCATE = 2'd2,
    OP_PICKUP = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_PRESENT = 2'd1,
    ST_MISSING = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  // Broadcast control from the sequencer to every cell.
  typedef struct packed {
    logic              compare;
    logic              drop;
    logic              append;
    logic [CODE_W-1:0] code;
  } cell_ctrl_t;

endpackage

// ----- hw/rtl/ordered_unique_set_table.sv -----
// Top level of the ordered unique set table: sequencer, cell row and result register.
//
//  channel   direction  transfer                signals
//  command   in         start && !busy         operation, value_code, position
//  result    out        done (one cycle)       status, found_index, picked_value, entry_count
//
// Insert, remove and locate: compare at the transfer edge, apply in the next cycle;
// done follows in the cycle after the apply, and a new command is taken in that cycle.
// Pickup on a non-empty set first waits in S_MOD: POS_W remainder steps in the
// bit-serial unit, then the sequencer sees its done and moves to apply.
// Reset clears the count and the sequencer; entry contents are left as they are.
// The receiver cannot stall: each result stands for exactly one cycle.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ordered_unique_set_table #(
  parameter int CAPACITY = ous_pkg::CAPACITY_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    operation,
  input  logic [ous_pkg::CODE_W-1:0]    value_code,
  input  logic [ous_pkg::POS_W-1:0]     position,
  output logic                          done,
  output logic [1:0]                    status,
  output logic [ous_pkg::IDX_OUT_W-1:0] found_index,
  output logic [ous_pkg::CODE_W-1:0]    picked_value,
  output logic [ous_pkg::CNT_OUT_W-1:0] entry_count
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_MOD   = 3'b010,
    S_APPLY = 3'b100
  } state_t;

  state_t                   state;
  ous_pkg::op_t             op_q;
  logic [ous_pkg::CODE_W-1:0] code_q;
  logic [CW-1:0]            count;
  logic [CW-1:0]            count_next;

  logic                     accept;
  logic                     mod_start;
  logic [CW-1:0]            rem;
  logic                     mod_done;

  ous_pkg::cell_ctrl_t      ctrl;
  logic [ous_pkg::CODE_W-1:0] entry [CAPACITY];
  logic [CAPACITY-1:0]      match;

  logic                     any_hit;
  logic [IW-1:0]            hit_idx;
  logic [IW-1:0]            at;
  logic [ous_pkg::CODE_W-1:0] picked;
  ous_pkg::status_t         status_next;
  logic [ous_pkg::IDX_OUT_W-1:0] index_next;
  logic [ous_pkg::CODE_W-1:0] picked_next;
  logic                     do_drop;
  logic                     do_append;

  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign mod_start = accept && (ous_pkg::op_t'(operation) == ous_pkg::OP_PICKUP)
                     && (count != '0);

  ous_mod #(.CW(CW)) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (position),
    .divisor  (count),
    .rem      (rem),
    .done     (mod_done)
  );

  // values are distinct, so at most one cell matches: the index is an OR of cell numbers
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (match[i]) begin
        hit_idx = hit_idx | IW'(i);
      end
    end
  end

  assign any_hit = |match;
  assign at      = (op_q == ous_pkg::OP_PICKUP) ? IW'(rem) : hit_idx;

  always_comb begin
    picked = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (IW'(i) == at) begin
        picked = picked | entry[i];
      end
    end
  end

  always_comb begin
    status_next = ous_pkg::ST_OK;
    index_next  = '0;
    picked_next = '0;
    count_next  = count;
    do_drop     = 1'b0;
    do_append   = 1'b0;
    case (op_q)
      ous_pkg::OP_INSERT: begin
        if (any_hit) begin
          status_next = ous_pkg::ST_PRESENT;
        end else if (count >= CW'(CAPACITY)) begin
          status_next = ous_pkg::ST_FULL;
        end else begin
          index_next = ous_pkg::IDX_OUT_W'(count);
          count_next = count + CW'(1);
          do_append  = 1'b1;
        end
      end
      ous_pkg::OP_REMOVE: begin
        if (!any_hit) begin
          status_next = ous_pkg::ST_MISSING;
        end else begin
          index_next = ous_pkg::IDX_OUT_W'(hit_idx);
          count_next = count - CW'(1);
          do_drop    = 1'b1;
        end
      end
      ous_pkg::OP_LOCATE: begin
        if (!any_hit) begin
          status_next = ous_pkg::ST_MISSING;
        end else begin
          index_next = ous_pkg::IDX_OUT_W'(hit_idx);
        end
      end
      ous_pkg::OP_PICKUP: begin
        if (count == '0) begin
          status_next = ous_pkg::ST_MISSING;
        end else begin
          index_next  = ous_pkg::IDX_OUT_W'(at);
          picked_next = picked;
          count_next  = count - CW'(1);
          do_drop     = 1'b1;
        end
      end
      default: begin
        status_next = ous_pkg::ST_MISSING;
      end
    endcase
  end

  always_comb begin
    ctrl.compare = accept;
    ctrl.drop    = (state == S_APPLY) && do_drop;
    ctrl.append  = (state == S_APPLY) && do_append;
    ctrl.code    = accept ? value_code : code_q;
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [ous_pkg::CODE_W-1:0] upper;
    if (g == CAPACITY - 1) begin : g_last
      assign upper = entry[g];
    end else begin : g_mid
      assign upper = entry[g + 1];
    end
    ous_cell #(.IDX(g), .CW(CW), .IW(IW)) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .count      (count),
      .at         (at),
      .next_entry (upper),
      .entry      (entry[g]),
      .match      (match[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= mod_start ? S_MOD : S_APPLY;
          end
        end
        S_MOD: begin
          if (mod_done) begin
            state <= S_APPLY;
          end
        end
        S_APPLY: begin
          count <= count_next;
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q   <= ous_pkg::op_t'(operation);
      code_q <= value_code;
    end
    if (state == S_APPLY) begin
      status       <= status_next;
      found_index  <= index_next;
      picked_value <= picked_next;
      entry_count  <= ous_pkg::CNT_OUT_W'(count_next);
    end
  end

  `ASSERT_CHECK(a_done_after_apply, clk, rst, done |-> $past(state == S_APPLY))
  `ASSERT_CHECK(a_count_bounded, clk, rst, count <= CW'(CAPACITY))
  `ASSERT_CHECK(a_single_match, clk, rst, (state == S_APPLY) |-> $onehot0(match))
  `ASSERT_CHECK(a_mod_only_pickup, clk, rst, (state == S_MOD) |-> (op_q == ous_pkg::OP_PICKUP))
  `ASSERT_CHECK(a_insert_grows, clk, rst,
    ((state == S_APPLY) && do_append) |=> (count == $past(count) + CW'(1)))

endmodule

// ----- hw/rtl/ous_cell.sv -----
// One storage cell of the set: holds one entry, compares it, shifts from its neighbour.
`timescale 1ns / 1ps
module ous_cell #(
  parameter int IDX = 0,
  parameter int CW  = $clog2(ous_pkg::CAPACITY_DEF + 1),
  parameter int IW  = $clog2(ous_pkg::CAPACITY_DEF)
) (
  input  logic                       clk,
  input  ous_pkg::cell_ctrl_t        ctrl,
  input  logic [CW-1:0]              count,
  input  logic [IW-1:0]              at,
  input  logic [ous_pkg::CODE_W-1:0] next_entry,
  output logic [ous_pkg::CODE_W-1:0] entry,
  output logic                       match
);

  logic occupied;

  assign occupied = CW'(IDX) < count;

  always_ff @(posedge clk) begin
    if (ctrl.compare) begin
      match <= occupied && (entry == ctrl.code);
    end
    // closing the gap: every cell at or above the dropped place takes its upper neighbour
    if (ctrl.drop && (IW'(IDX) >= at)) begin
      entry <= next_entry;
    end else if (ctrl.append && (CW'(IDX) == count)) begin
      entry <= ctrl.code;
    end
  end

endmodule

// ----- hw/rtl/ous_mod.sv -----
// Bit-serial remainder unit: position modulo the current count.
`timescale 1ns / 1ps
module ous_mod #(
  parameter int CW = $clog2(ous_pkg::CAPACITY_DEF + 1)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [ous_pkg::POS_W-1:0] dividend,
  input  logic [CW-1:0]             divisor,
  output logic [CW-1:0]             rem,
  output logic                      done
);

  localparam int SW = $clog2(ous_pkg::POS_W + 1);

  logic [SW-1:0]             step;
  logic [ous_pkg::POS_W-1:0] num;
  logic [CW:0]               trial;

  assign trial = {rem, num[ous_pkg::POS_W-1]};
  assign done  = (step == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else if (start) begin
      step <= SW'(ous_pkg::POS_W);
    end else if (step != '0) begin
      step <= step - SW'(1);
    end
  end

  // restoring step: one dividend bit a cycle, rem stays below divisor
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      num <= dividend;
    end else if (step != '0) begin
      if (trial >= {1'b0, divisor}) begin
        rem <= CW'(trial - {1'b0, divisor});
      end else begin
        rem <= CW'(trial);
      end
      num <= num << 1;
    end
  end

endmodule

// ----- dv/ordered_unique_set_table_tb.sv -----
// Self-checking testbench for the ordered unique set table.
`timescale 1ns / 1ps
module ordered_unique_set_table_tb;

  localparam int SET_CAP = ous_pkg::CAPACITY_DEF;
  localparam int RAND_ITEMS = 1630;
  localparam int DIR_ROWS = 22;
  localparam int WATCHDOG_LIMIT = 400;
  localparam int TAIL_CYCLES = 16;
  localparam int MAX_REPORTS = 30;

  typedef struct packed {
    ous_pkg::status_t                status;
    logic [ous_pkg::IDX_OUT_W-1:0]   index;
    logic [ous_pkg::CODE_W-1:0]      picked;
    logic [ous_pkg::CNT_OUT_W-1:0]   count;
  } set_result_t;

  typedef struct packed {
    ous_pkg::op_t               op;
    logic [ous_pkg::CODE_W-1:0] code;
    logic [ous_pkg::POS_W-1:0]  pos;
    bit                         typed;
    set_result_t                want;
  } dir_row_t;

  typedef enum int { MODE_GROW, MODE_SHRINK, MODE_CHURN } traffic_mode_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          start = 1'b0;
  logic                          busy;
  logic [1:0]                    operation = ous_pkg::OP_INSERT;
  logic [ous_pkg::CODE_W-1:0]    value_code = '0;
  logic [ous_pkg::POS_W-1:0]     position = '0;
  logic                          done;
  logic [1:0]                    status;
  logic [ous_pkg::IDX_OUT_W-1:0] found_index;
  logic [ous_pkg::CODE_W-1:0]    picked_value;
  logic [ous_pkg::CNT_OUT_W-1:0] entry_count;

  // own copy of the table contents
  logic [ous_pkg::CODE_W-1:0] set_slots [SET_CAP];
  int                         set_size = 0;

  set_result_t expected_results_q [$];
  dir_row_t    dir_rows [DIR_ROWS];

  int mismatches = 0;
  int commands_sent = 0;
  int results_seen = 0;
  int op_counts [4] = '{0, 0, 0, 0};
  int status_counts [4] = '{0, 0, 0, 0};
  int full_hits = 0;
  int idle_cycles = 0;
  int burst_left = 1;

  ordered_unique_set_table dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .operation    (operation),
    .value_code   (value_code),
    .position     (position),
    .done         (done),
    .status       (status),
    .found_index  (found_index),
    .picked_value (picked_value),
    .entry_count  (entry_count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic report_mismatch(string what);
    if (mismatches < MAX_REPORTS)
      $display("[%0t] mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  function automatic int slot_of(logic [ous_pkg::CODE_W-1:0] code);
    for (int i = 0; i < set_size; i++)
      if (set_slots[i] == code)
        return i;
    return -1;
  endfunction

  function automatic void close_gap(int at);
    for (int i = at; i + 1 < set_size; i++)
      set_slots[i] = set_slots[i + 1];
    set_size--;
  endfunction

  function automatic set_result_t predict_set_op(ous_pkg::op_t op,
                                                 logic [ous_pkg::CODE_W-1:0] code,
                                                 logic [ous_pkg::POS_W-1:0] pos);
    set_result_t r;
    int at;
    r = '0;
    at = slot_of(code);
    case (op)
      ous_pkg::OP_INSERT: begin
        // a present code wins over a full table
        if (at >= 0)
          r.status = ous_pkg::ST_PRESENT;
        else if (set_size >= SET_CAP)
          r.status = ous_pkg::ST_FULL;
        else begin
          set_slots[set_size] = code;
          r.index = ous_pkg::IDX_OUT_W'(set_size);
          set_size++;
        end
      end
      ous_pkg::OP_REMOVE: begin
        if (at < 0)
          r.status = ous_pkg::ST_MISSING;
        else begin
          r.index = ous_pkg::IDX_OUT_W'(at);
          close_gap(at);
        end
      end
      ous_pkg::OP_LOCATE: begin
        if (at < 0)
          r.status = ous_pkg::ST_MISSING;
        else
          r.index = ous_pkg::IDX_OUT_W'(at);
      end
      default: begin
        if (set_size == 0)
          r.status = ous_pkg::ST_MISSING;
        else begin
          at = int'(pos) % set_size;
          r.index = ous_pkg::IDX_OUT_W'(at);
          r.picked = set_slots[at];
          close_gap(at);
        end
      end
    endcase
    r.count = ous_pkg::CNT_OUT_W'(set_size);
    return r;
  endfunction

  // With 64 codes and 64 slots there is always an absent code below capacity.
  function automatic logic [ous_pkg::CODE_W-1:0] pick_absent_code();
    int base;
    base = $urandom_range(0, 63);
    for (int k = 0; k < 64; k++)
      if (slot_of(ous_pkg::CODE_W'(base + k)) < 0)
        return ous_pkg::CODE_W'(base + k);
    return ous_pkg::CODE_W'(base);
  endfunction

  // Drives one command and holds it until the transfer.
  task automatic issue_command(ous_pkg::op_t op, logic [ous_pkg::CODE_W-1:0] code,
                               logic [ous_pkg::POS_W-1:0] pos,
                               bit typed, set_result_t want);
    set_result_t predicted;
    start      <= 1'b1;
    operation  <= op;
    value_code <= code;
    position   <= pos;
    @(posedge clk);
    while (busy)
      @(posedge clk);
    predicted = predict_set_op(op, code, pos);
    expected_results_q.push_back(typed ? want : predicted);
    commands_sent++;
    op_counts[op]++;
  endtask

  // Bursts of back-to-back commands separated by random gaps.
  task automatic pace_sender();
    burst_left--;
    if (burst_left <= 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 8);
    end
  endtask

  always @(posedge clk) begin
    set_result_t exp_r;
    if (!rst && done) begin
      results_seen++;
      status_counts[status]++;
      if (entry_count == ous_pkg::CNT_OUT_W'(SET_CAP))
        full_hits++;
      if (expected_results_q.size() == 0)
        report_mismatch("result with no command outstanding");
      else begin
        exp_r = expected_results_q.pop_front();
        if (status !== exp_r.status)
          report_mismatch($sformatf("status %0d, expected %0d", status, exp_r.status));
        if (found_index !== exp_r.index)
          report_mismatch($sformatf("found_index %0d, expected %0d",
                                    found_index, exp_r.index));
        if (picked_value !== exp_r.picked)
          report_mismatch($sformatf("picked_value %0d, expected %0d",
                                    picked_value, exp_r.picked));
        if (entry_count !== exp_r.count)
          report_mismatch($sformatf("entry_count %0d, expected %0d",
                                    entry_count, exp_r.count));
      end
    end
  end

  // Watchdog: a run with no transfer in either direction for too long is hung.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("ordered_unique_set_table_tb: FAIL");
      $finish;
    end
  end

  initial begin
    traffic_mode_t mode;
    int churn_left;
    int roll;
    ous_pkg::op_t op;
    logic [ous_pkg::CODE_W-1:0] code;

    // fields: op, code, position, typed, expected {status, index, picked, count}
    dir_rows = '{
      '{ous_pkg::OP_PICKUP, 6'd0,  6'd63, 1'b1, '{ous_pkg::ST_MISSING, 6'd0, 6'd0, 7'd0}},
      '{ous_pkg::OP_REMOVE, 6'd63, 6'd0,  1'b1, '{ous_pkg::ST_MISSING, 6'd0, 6'd0, 7'd0}},
      '{ous_pkg::OP_LOCATE, 6'd0,  6'd0,  1'b1, '{ous_pkg::ST_MISSING, 6'd0, 6'd0, 7'd0}},
      '{ous_pkg::OP_INSERT, 6'd0,  6'd0,  1'b1, '{ous_pkg::ST_OK,      6'd0, 6'd0, 7'd1}},
      '{ous_pkg::OP_INSERT, 6'd63, 6'd63, 1'b1, '{ous_pkg::ST_OK,      6'd1, 6'd0, 7'd2}},
      '{ous_pkg::OP_INSERT, 6'd0,  6'd0,  1'b1, '{ous_pkg::ST_PRESENT, 6'd0, 6'd0, 7'd2}},
      '{ous_pkg::OP_LOCATE, 6'd63, 6'd0,  1'b1, '{ous_pkg::ST_OK,      6'd1, 6'd0, 7'd2}},
      '{ous_pkg::OP_LOCATE, 6'd0,  6'd63, 1'b1, '{ous_pkg::ST_OK,      6'd0, 6'd0, 7'd2}},
      '{ous_pkg::OP_INSERT, 6'd42, 6'd21, 1'b1, '{ous_pkg::ST_OK,      6'd2, 6'd0, 7'd3}},
      '{ous_pkg::OP_INSERT, 6'd21, 6'd42, 1'b1, '{ous_pkg::ST_OK,      6'd3, 6'd0, 7'd4}},
      '{ous_pkg::OP_PICKUP, 6'd0,  6'd63, 1'b0, '0},
      '{ous_pkg::OP_REMOVE, 6'd63, 6'd0,  1'b0, '0},
      '{ous_pkg::OP_LOCATE, 6'd42, 6'd0,  1'b0, '0},
      '{ous_pkg::OP_PICKUP, 6'd63, 6'd0,  1'b0, '0},
      '{ous_pkg::OP_INSERT, 6'd63, 6'd0,  1'b0, '0},
      '{ous_pkg::OP_PICKUP, 6'd0,  6'd1,  1'b0, '0},
      '{ous_pkg::OP_REMOVE, 6'd42, 6'd0,  1'b0, '0},
      '{ous_pkg::OP_REMOVE, 6'd42, 6'd0,  1'b1, '{ous_pkg::ST_MISSING, 6'd0, 6'd0, 7'd0}},
      '{ous_pkg::OP_PICKUP, 6'd0,  6'd0,  1'b1, '{ous_pkg::ST_MISSING, 6'd0, 6'd0, 7'd0}},
      '{ous_pkg::OP_INSERT, 6'd63, 6'd0,  1'b1, '{ous_pkg::ST_OK,      6'd0, 6'd0, 7'd1}},
      '{ous_pkg::OP_PICKUP, 6'd0,  6'd63, 1'b0, '0},
      '{ous_pkg::OP_LOCATE, 6'd63, 6'd0,  1'b1, '{ous_pkg::ST_MISSING, 6'd0, 6'd0, 7'd0}}
    };

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_ROWS; i++) begin
      issue_command(dir_rows[i].op, dir_rows[i].code, dir_rows[i].pos,
                    dir_rows[i].typed, dir_rows[i].want);
      pace_sender();
    end

    // Random traffic cycles through filling to capacity, draining to empty and a mix.
    mode = MODE_GROW;
    churn_left = 0;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      roll = $urandom_range(0, 99);
      case (mode)
        MODE_GROW:
          op = (roll < 70) ? ous_pkg::OP_INSERT :
               (roll < 85) ? ous_pkg::OP_LOCATE :
               (roll < 90) ? ous_pkg::OP_REMOVE : ous_pkg::OP_PICKUP;
        MODE_SHRINK:
          op = (roll < 10) ? ous_pkg::OP_INSERT :
               (roll < 50) ? ous_pkg::OP_REMOVE :
               (roll < 90) ? ous_pkg::OP_PICKUP : ous_pkg::OP_LOCATE;
        default:
          op = ous_pkg::op_t'(roll % 4);
      endcase
      roll = $urandom_range(0, 99);
      if (op == ous_pkg::OP_INSERT && set_size < SET_CAP && roll < 75)
        code = pick_absent_code();
      else if (op != ous_pkg::OP_INSERT && set_size > 0 && roll < 70)
        code = set_slots[$urandom_range(0, set_size - 1)];
      else
        code = ous_pkg::CODE_W'($urandom_range(0, 63));
      issue_command(op, code, ous_pkg::POS_W'($urandom_range(0, 63)), 1'b0, '0);
      pace_sender();

      case (mode)
        MODE_GROW:
          if (set_size == SET_CAP && $urandom_range(0, 3) == 0)
            mode = MODE_SHRINK;
        MODE_SHRINK:
          if (set_size == 0 && $urandom_range(0, 3) == 0) begin
            mode = MODE_CHURN;
            churn_left = $urandom_range(30, 120);
          end
        default: begin
          churn_left--;
          if (churn_left <= 0)
            mode = MODE_GROW;
        end
      endcase
    end

    start <= 1'b0;
    while (expected_results_q.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d commands (insert %0d, remove %0d, locate %0d, pickup %0d), %0d results",
             commands_sent, op_counts[ous_pkg::OP_INSERT], op_counts[ous_pkg::OP_REMOVE],
             op_counts[ous_pkg::OP_LOCATE], op_counts[ous_pkg::OP_PICKUP], results_seen);
    $display("status ok/present/missing/full %0d/%0d/%0d/%0d, table at capacity %0d times",
             status_counts[ous_pkg::ST_OK], status_counts[ous_pkg::ST_PRESENT],
             status_counts[ous_pkg::ST_MISSING], status_counts[ous_pkg::ST_FULL],
             full_hits);
    if (mismatches == 0)
      $display("ordered_unique_set_table_tb: PASS");
    else
      $display("ordered_unique_set_table_tb: FAIL");
    $finish;
  end

endmodule
